// ----- rtl/ifmt_pkg.sv -----
// Shared constants and types for the signed decimal formatter.
`timescale 1ns / 1ps

package ifmt_pkg;

  localparam int WIDTH_LIMIT_DEF = 63;
  localparam int VALUE_BITS_DEF  = 64;

  // Text positions and lengths: total text never exceeds 64 characters.
  localparam int TXT_W = 7;

  localparam logic [1:0] LEN_32   = 2'd0;
  localparam logic [1:0] LEN_8    = 2'd1;
  localparam logic [1:0] LEN_16   = 2'd2;
  localparam logic [1:0] LEN_FULL = 2'd3;

  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic shift;
    logic count;
    logic layout;
    logic emit;
  } ifmt_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_last;
  } ifmt_sts_t;

endpackage

// ----- rtl/ifmt_ctrl.sv -----
// Sequencer for load, conversion, layout and character emission.
`timescale 1ns / 1ps

module ifmt_ctrl
  import ifmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ifmt_sts_t sts,
  output ifmt_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_LAYOUT,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.count  = 1'b1;
        state_next = ST_LAYOUT;
      end
      ST_LAYOUT: begin
        cmd.layout = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- rtl/ifmt_datapath.sv -----
// Sign handling, shift-and-add-3 conversion, text layout and character output.
`timescale 1ns / 1ps

module ifmt_datapath
  import ifmt_pkg::*;
#(
  parameter int WIDTH_LIMIT = WIDTH_LIMIT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ifmt_cmd_t   cmd,
  output ifmt_sts_t   sts,
  input  logic [63:0] value,
  input  logic [1:0]  length_mod,
  input  logic [5:0]  field_width,
  input  logic        has_precision,
  input  logic [5:0]  precision,
  input  logic        flag_plus,
  input  logic        flag_space,
  input  logic        flag_left,
  input  logic        flag_zero,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        empty_res,
  output logic [5:0]  char_count
);

  localparam int DIG_MAX = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int DIG_IW  = $clog2(DIG_MAX);
  localparam int CNT_W   = $clog2(VALUE_BITS);
  localparam int CAP     = (WIDTH_LIMIT < 64) ? WIDTH_LIMIT : 64;
  localparam logic [TXT_W-1:0] CAP_L = TXT_W'(CAP);

  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            bcd [DIG_MAX];
  logic [CNT_W-1:0]      cnt;
  logic [7:0]            sign_ch;
  logic                  has_prec;
  logic [5:0]            prec;
  logic [5:0]            width;
  logic                  left;
  logic                  zpad;
  logic [TXT_W-1:0]      ndig;
  logic [TXT_W-1:0]      b1, b2, b3, b4, n, pos;

  // load
  logic [63:0] ext;
  logic [63:0] mag_full;
  logic        neg;
  logic [7:0]  sign_c;

  always_comb begin
    ext = value;
    case (length_mod)
      LEN_8:  ext = {{56{value[7]}}, value[7:0]};
      LEN_16: ext = {{48{value[15]}}, value[15:0]};
      LEN_32: ext = {{32{value[31]}}, value[31:0]};
      default: begin
        for (int i = VALUE_BITS; i < 64; i++) ext[i] = value[VALUE_BITS-1];
      end
    endcase
    neg      = ext[63];
    mag_full = neg ? (64'd0 - ext) : ext;
    if (neg)             sign_c = CH_MINUS;
    else if (flag_plus)  sign_c = CH_PLUS;
    else if (flag_space) sign_c = CH_SPACE;
    else                 sign_c = CH_NONE;
  end

  // shift-and-add-3
  logic [3:0] adj [DIG_MAX];

  always_comb begin
    for (int i = 0; i < DIG_MAX; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  // significant digit count
  logic [TXT_W-1:0] ndig_c;
  logic             allz;

  always_comb begin
    ndig_c = '0;
    allz   = 1'b1;
    for (int i = 0; i < DIG_MAX; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig_c = TXT_W'(i + 1);
        allz   = 1'b0;
      end
    end
    if (allz) ndig_c = (has_prec && prec == 6'd0) ? '0 : TXT_W'(1);
  end

  // layout
  logic [TXT_W-1:0] zeros, body, pad, lead, zn, trail, sg;
  logic [TXT_W-1:0] b1_c, b2_c, b3_c, b4_c, total;

  always_comb begin
    zeros = (has_prec && {1'b0, prec} > ndig) ? ({1'b0, prec} - ndig) : '0;
    sg    = (sign_ch != CH_NONE) ? TXT_W'(1) : '0;
    body  = zeros + ndig + sg;
    pad   = ({1'b0, width} > body) ? ({1'b0, width} - body) : '0;
    lead  = (!left && !zpad) ? pad : '0;
    zn    = zeros + (zpad ? pad : '0);
    trail = left ? pad : '0;
    b1_c  = lead;
    b2_c  = b1_c + sg;
    b3_c  = b2_c + zn;
    b4_c  = b3_c + ndig;
    total = b4_c + trail;
  end

  // character select
  logic [TXT_W-1:0] dig_pos;
  logic [3:0]       dig;
  logic [7:0]       ch_c;
  logic             last_c;

  always_comb begin
    dig_pos = b4 - TXT_W'(1) - pos;
    dig     = bcd[dig_pos[DIG_IW-1:0]];
    if (n == '0)      ch_c = CH_NONE;
    else if (pos < b1) ch_c = CH_SPACE;
    else if (pos < b2) ch_c = sign_ch;
    else if (pos < b3) ch_c = CH_ZERO;
    else if (pos < b4) ch_c = CH_ZERO + {4'd0, dig};
    else               ch_c = CH_SPACE;
    last_c = (n == '0) || (pos == n - TXT_W'(1));
  end

  assign sts.conv_done = (cnt == '0);
  assign sts.emit_last = last_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_full[VALUE_BITS-1:0];
      cnt      <= CNT_W'(VALUE_BITS - 1);
      sign_ch  <= sign_c;
      has_prec <= has_precision;
      prec     <= precision;
      width    <= field_width;
      left     <= flag_left;
      zpad     <= flag_zero && !has_precision && !flag_left;
      for (int i = 0; i < DIG_MAX; i++) bcd[i] <= 4'd0;
    end
    if (cmd.shift) begin
      bcd[0] <= {adj[0][2:0], mag[VALUE_BITS-1]};
      for (int i = 1; i < DIG_MAX; i++) bcd[i] <= {adj[i][2:0], adj[i-1][3]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.count) begin
      ndig <= ndig_c;
    end
    if (cmd.layout) begin
      b1  <= b1_c;
      b2  <= b2_c;
      b3  <= b3_c;
      b4  <= b4_c;
      n   <= (total > CAP_L) ? CAP_L : total;
      pos <= '0;
    end
    if (cmd.emit) begin
      pos        <= pos + TXT_W'(1);
      out_char   <= ch_c;
      last       <= last_c;
      empty_res  <= (n == '0);
      char_count <= last_c ? n[5:0] : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

// ----- rtl/int_decimal_formatter.sv -----
// Top level of the printf-style signed decimal formatter.
//
// A transaction is taken when start is high and busy is low; busy then stays
// high until the final character has been issued. The operand is converted to
// decimal by a shift-and-add-3 loop that consumes one magnitude bit per clock
// until all VALUE_BITS bits are in; a digit count step and a layout step follow,
// and then the N characters are issued, where N is the number of characters
// (at least one result, up to WIDTH_LIMIT). Each character appears for
// exactly one cycle with strobe high, in reading order, one per clock with
// no gaps; the receiver cannot stall the output. An item that prints nothing
// gives one result with empty_res and last set.
`timescale 1ns / 1ps

module int_decimal_formatter
  import ifmt_pkg::*;
#(
  parameter int WIDTH_LIMIT = WIDTH_LIMIT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [1:0]  length_mod,
  input  logic [5:0]  field_width,
  input  logic        has_precision,
  input  logic [5:0]  precision,
  input  logic        flag_plus,
  input  logic        flag_space,
  input  logic        flag_left,
  input  logic        flag_zero,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        empty_res,
  output logic [5:0]  char_count
);

  ifmt_cmd_t cmd;
  ifmt_sts_t sts;

  ifmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ifmt_datapath #(
    .WIDTH_LIMIT (WIDTH_LIMIT),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .value         (value),
    .length_mod    (length_mod),
    .field_width   (field_width),
    .has_precision (has_precision),
    .precision     (precision),
    .flag_plus     (flag_plus),
    .flag_space    (flag_space),
    .flag_left     (flag_left),
    .flag_zero     (flag_zero),
    .strobe        (strobe),
    .out_char      (out_char),
    .last          (last),
    .empty_res     (empty_res),
    .char_count    (char_count)
  );

endmodule

// ----- rtl/ifmt_checker.sv -----
// Port-level checks for the decimal formatter, bound to the top level.
`timescale 1ns / 1ps

module ifmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       last,
  input logic       empty_res,
  input logic [5:0] char_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transaction accepted but busy not raised");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a transaction's character stream");

  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy dropped before final character");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> last && (char_count == 6'd0))
    else $error("empty result not final or count nonzero");

  a_count_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> (char_count == 6'd0) && !empty_res)
    else $error("count or empty flag set on a middle character");

endmodule

bind int_decimal_formatter ifmt_checker u_ifmt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .last       (last),
  .empty_res  (empty_res),
  .char_count (char_count)
);

// ----- tb/tb_int_decimal_formatter.sv -----
// Self-checking testbench for int_decimal_formatter: directed and random %d conversions.
`timescale 1ns / 1ps

module tb_int_decimal_formatter;
  import ifmt_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  length_mod;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  precision;
    logic        flag_plus;
    logic        flag_space;
    logic        flag_left;
    logic        flag_zero;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic [5:0] count;
  } fmt_char_t;

  class decimal_text_checker;
    fmt_char_t expected_chars[$];
    int errors;
    int items_seen;
    int chars_seen;
    int empty_items;
    int cut_items;

    function new();
      errors = 0;
      items_seen = 0;
      chars_seen = 0;
      empty_items = 0;
      cut_items = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void predict_text(fmt_item_t it);
      logic [63:0] v;
      logic [63:0] mag;
      logic [7:0]  digs[24];
      logic [7:0]  sign_ch;
      logic [7:0]  text[$];
      int ndig;
      int zeros;
      int body;
      int pad;
      int n;
      bit zpad;
      case (it.length_mod)
        LEN_8:   v = {{56{it.value[7]}}, it.value[7:0]};
        LEN_16:  v = {{48{it.value[15]}}, it.value[15:0]};
        LEN_32:  v = {{32{it.value[31]}}, it.value[31:0]};
        default: v = it.value;
      endcase
      mag = v[63] ? -v : v;
      ndig = 0;
      if (!(it.has_precision && it.precision == 6'd0 && mag == 64'd0)) begin
        do begin
          digs[ndig] = CH_ZERO + 8'(mag % 64'd10);
          ndig++;
          mag = mag / 64'd10;
        end while (mag != 64'd0);
      end
      if (v[63]) sign_ch = CH_MINUS;
      else if (it.flag_plus) sign_ch = CH_PLUS;
      else if (it.flag_space) sign_ch = CH_SPACE;
      else sign_ch = CH_NONE;
      zpad = it.flag_zero && !it.has_precision && !it.flag_left;
      zeros = (it.has_precision && int'(it.precision) > ndig) ? int'(it.precision) - ndig : 0;
      body = ((sign_ch != CH_NONE) ? 1 : 0) + zeros + ndig;
      pad = (int'(it.field_width) > body) ? int'(it.field_width) - body : 0;

      if (!it.flag_left && !zpad)
        for (int i = 0; i < pad; i++) text.push_back(CH_SPACE);
      if (sign_ch != CH_NONE) text.push_back(sign_ch);
      if (zpad)
        for (int i = 0; i < pad; i++) text.push_back(CH_ZERO);
      for (int i = 0; i < zeros; i++) text.push_back(CH_ZERO);
      for (int i = ndig; i > 0; i--) text.push_back(digs[i - 1]);
      if (it.flag_left)
        for (int i = 0; i < pad; i++) text.push_back(CH_SPACE);

      items_seen++;
      if (text.size() == 0) begin
        empty_items++;
        expected_chars.push_back('{ch: CH_NONE, last: 1'b1, empty: 1'b1, count: 6'd0});
      end else begin
        n = text.size();
        if (n > WIDTH_LIMIT_DEF) begin
          n = WIDTH_LIMIT_DEF;
          cut_items++;
        end
        for (int i = 0; i < n; i++)
          expected_chars.push_back('{ch: text[i], last: (i == n - 1), empty: 1'b0,
                                     count: (i == n - 1) ? 6'(n) : 6'd0});
      end
    endfunction

    function void check_char(logic [7:0] ch, logic lst, logic emp, logic [5:0] cnt);
      fmt_char_t exp;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("character 0x%0h with no transaction pending", ch);
        errors++;
        return;
      end
      exp = expected_chars.pop_front();
      if (!exp.empty && ch !== exp.ch) begin
        $error("out_char: expected 0x%0h, got 0x%0h", exp.ch, ch);
        errors++;
      end
      if (lst !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, lst);
        errors++;
      end
      if (emp !== exp.empty) begin
        $error("empty_res: expected %0b, got %0b", exp.empty, emp);
        errors++;
      end
      if (cnt !== exp.count) begin
        $error("char_count: expected %0d, got %0d", exp.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  fmt_item_t  drv = '0;
  logic       busy;
  logic       strobe;
  logic [7:0] out_char;
  logic       last;
  logic       empty_res;
  logic [5:0] char_count;

  decimal_text_checker sb = new();

  always #5 clk = ~clk;

  int_decimal_formatter uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (drv.value),
    .length_mod   (drv.length_mod),
    .field_width  (drv.field_width),
    .has_precision(drv.has_precision),
    .precision    (drv.precision),
    .flag_plus    (drv.flag_plus),
    .flag_space   (drv.flag_space),
    .flag_left    (drv.flag_left),
    .flag_zero    (drv.flag_zero),
    .strobe       (strobe),
    .out_char     (out_char),
    .last         (last),
    .empty_res    (empty_res),
    .char_count   (char_count)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.predict_text(drv);
      if (strobe) sb.check_char(out_char, last, empty_res, char_count);
    end
  end

  function automatic fmt_item_t mk(logic [63:0] v, logic [1:0] lm, int w, bit hp, int p,
                                   bit plus, bit space, bit left, bit zero);
    return '{value: v, length_mod: lm, field_width: 6'(w), has_precision: hp,
             precision: 6'(p), flag_plus: plus, flag_space: space, flag_left: left,
             flag_zero: zero};
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    int sz;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return r;
      1: return 64'($signed($urandom_range(0, 2000)) - 1000);
      2: return 64'd0;
      3: begin
        sz = 8 << $urandom_range(0, 3);
        r = (sz == 64) ? 64'd0 : (r >> sz) << sz;
        r = r | (((64'd1 << (sz - 1)) - 64'($urandom_range(0, 2))) & ((sz == 64) ? '1 :
            ((64'd1 << sz) - 1)));
        if ($urandom_range(0, 1)) r = r ^ ((sz == 64) ? '1 : ((64'd1 << sz) - 1));
        return r;
      end
      default: return r >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic fmt_item_t rand_item();
    fmt_item_t it;
    it.value = rand_value();
    it.length_mod = 2'($urandom_range(0, 3));
    it.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 20));
    it.has_precision = 1'($urandom_range(0, 1));
    it.precision = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 12));
    it.flag_plus = 1'($urandom_range(0, 1));
    it.flag_space = 1'($urandom_range(0, 1));
    it.flag_left = 1'($urandom_range(0, 1));
    it.flag_zero = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(fmt_item_t it);
    drv <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic hold_for_drain();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  fmt_item_t directed[$];

  initial begin
    directed.push_back(mk(64'd0, LEN_32, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'd0, LEN_32, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'd0, LEN_8, 5, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'd0, LEN_16, 0, 1, 0, 1, 0, 0, 0));
    directed.push_back(mk(64'd0, LEN_FULL, 3, 1, 0, 0, 1, 1, 0));
    directed.push_back(mk(64'h8000_0000_0000_0000, LEN_FULL, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'h7FFF_FFFF_FFFF_FFFF, LEN_FULL, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, LEN_FULL, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(mk(64'h1234_5678_8000_0000, LEN_32, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'hAAAA_AAAA_7FFF_FFFF, LEN_32, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(mk(64'h5555_5555_5555_5580, LEN_8, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'hFFFF_FFFF_FFFF_FF7F, LEN_8, 6, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk(64'h0000_0000_0000_8000, LEN_16, 10, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk(64'hFFFF_0000_0000_7FFF, LEN_16, 63, 0, 0, 1, 0, 0, 1));
    directed.push_back(mk(64'd42, LEN_32, 10, 1, 5, 0, 0, 0, 1));
    directed.push_back(mk(-64'sd42, LEN_FULL, 10, 0, 0, 0, 0, 1, 1));
    directed.push_back(mk(-64'sd7, LEN_FULL, 0, 1, 62, 0, 0, 0, 0));
    directed.push_back(mk(64'd7, LEN_32, 63, 1, 63, 1, 0, 0, 0));
    directed.push_back(mk(64'h7FFF_FFFF_FFFF_FFFF, LEN_FULL, 63, 0, 0, 0, 0, 1, 0));
    directed.push_back(mk(64'd12345, LEN_32, 8, 0, 0, 0, 1, 0, 1));
    directed.push_back(mk(64'd0, LEN_FULL, 0, 1, 63, 0, 0, 0, 0));
    directed.push_back(mk(64'h0000_0000_0000_00FF, LEN_8, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(64'd5, LEN_32, 0, 0, 0, 1, 1, 0, 0));
    directed.push_back(mk(64'd123, LEN_32, 0, 1, 2, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    hold_for_drain();

    for (int i = 0; i < 270; i++) begin
      send_item(rand_item());
      if (i < 220 && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) begin
          start <= 1'b0;
          while (busy) @(posedge clk);
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          idle_gap($urandom_range(1, 6));
        end
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Covered %0d transactions, %0d characters checked: %0d empty, %0d cut at limit",
             sb.items_seen, sb.chars_seen, sb.empty_items, sb.cut_items);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout with %0d characters outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
